// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the command parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== rtl/core/svac_pkg.sv =====
// Types and constants of the servo angle command parser.
package svac_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  servo_select;
        logic [14:0] angle_hundredths;
    } t_out_word;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_ONE        = 8'h31;
    localparam logic [7:0] CHAR_TWO        = 8'h32;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;

    localparam logic [1:0] SERVO_NONE = 2'd0;
    localparam logic [1:0] SERVO_ONE  = 2'd1;
    localparam logic [1:0] SERVO_TWO  = 2'd2;

    localparam logic [7:0]  WHOLE_MAX       = 8'd255;
    localparam logic [1:0]  FRAC_DIGITS_MAX = 2'd2;
    localparam logic [14:0] FULL_SCALE      = 15'd18000;

endpackage

// ===== rtl/core/servo_angle_command_parser.sv =====
// A frame's result passes the snapshot stage and the output register before it shows on o_out_valid.
// Throughput: one byte per cycle while the input is not stalled; bytes are taken while a result waits at the output.
// The parse state updates as each byte is taken; a frame snapshot stage and the
// output register form a two-deep queue, so the input stalls only when both are full.
// Reset: synchronous, active low; clears the parse state and empties both stages.
`include "assert_macros.svh"

module servo_angle_command_parser #(
    parameter int MAX_KEPT_CHARS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  svac_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output svac_pkg::t_out_word o_out_word
);
    import svac_pkg::*;

    localparam int KeptW = $clog2(MAX_KEPT_CHARS + 1);
    localparam logic [KeptW-1:0] KeptMax = KeptW'(MAX_KEPT_CHARS);

    logic [1:0]       r_servo, n_servo;
    logic [7:0]       r_prev, n_prev;
    logic [KeptW-1:0] r_kept, n_kept;
    logic             r_dot, n_dot;
    logic             r_ended, n_ended;
    logic [7:0]       r_whole, n_whole;
    logic [6:0]       r_frac, n_frac;
    logic [1:0]       r_fdig, n_fdig;

    logic             r_p_valid;
    logic [1:0]       r_p_servo;
    logic [7:0]       r_p_whole;
    logic [6:0]       r_p_frac;
    logic [1:0]       r_p_fdig;

    logic             r_o_valid;
    t_out_word        r_o_word, n_o_word;

    logic             s2_load;
    logic             s1_ready;
    logic             in_acc;
    logic [7:0]       c;
    logic             is_digit;
    logic             is_dot;
    logic [3:0]       digit;
    logic [11:0]      whole_acc;
    logic [14:0]      whole_scaled;
    logic [14:0]      frac_scaled;
    logic [14:0]      angle_sum;

    assign s2_load    = !r_o_valid || !i_out_stall;
    assign s1_ready   = !r_p_valid || s2_load;
    assign in_acc     = i_in_valid && s1_ready;
    assign o_in_stall = !s1_ready;

    assign c         = i_in_word.rx_byte;
    assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign is_dot    = (c == CHAR_DOT);
    assign digit     = 4'(c - CHAR_ZERO);
    assign whole_acc = 12'(r_whole) * 12'd10 + 12'(digit);

    always_comb begin
        n_servo = r_servo;
        n_prev  = r_prev;
        n_kept  = r_kept;
        n_dot   = r_dot;
        n_ended = r_ended;
        n_whole = r_whole;
        n_frac  = r_frac;
        n_fdig  = r_fdig;
        if (r_servo == SERVO_NONE) begin
            if (c == CHAR_UNDERSCORE && (r_prev == CHAR_ONE || r_prev == CHAR_TWO)) begin
                n_servo = (r_prev == CHAR_ONE) ? SERVO_ONE : SERVO_TWO;
            end
            n_prev = c;
        end else if (r_kept < KeptMax && (is_digit || is_dot)) begin
            n_kept = r_kept + 1'b1;
            if (!r_ended) begin
                if (is_dot) begin
                    if (r_dot) begin
                        n_ended = 1'b1;
                    end else begin
                        n_dot = 1'b1;
                    end
                end else if (!r_dot) begin
                    n_whole = (whole_acc > 12'(WHOLE_MAX)) ? WHOLE_MAX : whole_acc[7:0];
                end else if (r_fdig < FRAC_DIGITS_MAX) begin
                    n_frac = 7'(r_frac * 7'd10 + 7'(digit));
                    n_fdig = r_fdig + 1'b1;
                end
            end
        end
    end

    assign whole_scaled = 15'(r_p_whole) * 15'd100;
    assign frac_scaled  = (r_p_fdig == 2'd1) ? 15'(r_p_frac) * 15'd10 : 15'(r_p_frac);
    assign angle_sum    = whole_scaled + frac_scaled;

    always_comb begin
        n_o_word.servo_select = r_p_servo;
        if (r_p_servo == SERVO_NONE) begin
            n_o_word.angle_hundredths = '0;
        end else if (angle_sum > FULL_SCALE) begin
            n_o_word.angle_hundredths = FULL_SCALE;
        end else begin
            n_o_word.angle_hundredths = angle_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo   <= SERVO_NONE;
            r_prev    <= '0;
            r_kept    <= '0;
            r_dot     <= 1'b0;
            r_ended   <= 1'b0;
            r_whole   <= '0;
            r_frac    <= '0;
            r_fdig    <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_in_word.frame_end) begin
                    r_servo <= SERVO_NONE;
                    r_prev  <= '0;
                    r_kept  <= '0;
                    r_dot   <= 1'b0;
                    r_ended <= 1'b0;
                    r_whole <= '0;
                    r_frac  <= '0;
                    r_fdig  <= '0;
                end else begin
                    r_servo <= n_servo;
                    r_prev  <= n_prev;
                    r_kept  <= n_kept;
                    r_dot   <= n_dot;
                    r_ended <= n_ended;
                    r_whole <= n_whole;
                    r_frac  <= n_frac;
                    r_fdig  <= n_fdig;
                end
            end
            if (s1_ready) begin
                r_p_valid <= in_acc && i_in_word.frame_end;
            end
            if (s2_load) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_word.frame_end) begin
            r_p_servo <= n_servo;
            r_p_whole <= n_whole;
            r_p_frac  <= n_frac;
            r_p_fdig  <= n_fdig;
        end
        if (s2_load) begin
            r_o_word <= n_o_word;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

    `ASSERT_CLK(a_angle_range, i_clk, i_rst_n, r_o_valid |-> (r_o_word.angle_hundredths <= FULL_SCALE), "angle above full scale")
    `ASSERT_CLK(a_no_servo_zero, i_clk, i_rst_n, (r_o_valid && r_o_word.servo_select == SERVO_NONE) |-> (r_o_word.angle_hundredths == '0), "angle without servo marker")
    `ASSERT_NEXT(a_frame_snap, i_clk, i_rst_n, in_acc && i_in_word.frame_end, r_p_valid && r_servo == SERVO_NONE && r_kept == '0, "frame end not captured or state not cleared")
    `ASSERT_CLK(a_kept_bound, i_clk, i_rst_n, r_kept <= KeptMax, "kept count beyond limit")
    `ASSERT_CLK(a_chars_before_marker, i_clk, i_rst_n, (r_servo == SERVO_NONE) |-> (r_kept == '0 && r_whole == '0), "number kept before marker")

endmodule

// ===== test/servo_angle_command_parser_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the servo angle command parser, with directed and random frames.
module servo_angle_command_parser_test;
    import svac_pkg::*;

    localparam int KEPT_LIMIT     = 31;
    localparam int IDLE_BURST_MAX = 11;
    localparam int PRINT_CAP      = 40;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    t_in_word    tx_words[$];
    t_out_word   parsed_commands[$];
    t_out_word   oldest_command;

    int unsigned in_idle_pct    = 0;
    int unsigned out_idle_pct   = 0;
    int unsigned in_gap         = 0;
    int unsigned out_gap        = 0;
    int unsigned error_count    = 0;
    int unsigned bytes_queued   = 0;
    int unsigned bytes_taken    = 0;
    int unsigned frames_checked = 0;
    int unsigned segment_end;

    logic [1:0]  frame_servo   = SERVO_NONE;
    logic [7:0]  last_char     = '0;
    int unsigned kept_chars    = 0;
    bit          point_seen    = 1'b0;
    bit          number_closed = 1'b0;
    int unsigned int_part      = 0;
    int unsigned dec_part      = 0;
    int unsigned dec_count     = 0;

    servo_angle_command_parser #(
        .MAX_KEPT_CHARS(KEPT_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (error_count < PRINT_CAP) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic parse_char(input t_in_word w);
        logic [7:0]  c;
        int unsigned digit;
        int unsigned angle;
        t_out_word   cmd;
        c = w.rx_byte;
        digit = c - CHAR_ZERO;
        if (frame_servo == SERVO_NONE) begin
            if (c == CHAR_UNDERSCORE && (last_char == CHAR_ONE || last_char == CHAR_TWO)) begin
                frame_servo = (last_char == CHAR_ONE) ? SERVO_ONE : SERVO_TWO;
            end
            last_char = c;
        end else if (kept_chars < KEPT_LIMIT &&
                     ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_DOT)) begin
            kept_chars++;
            if (!number_closed) begin
                if (c == CHAR_DOT) begin
                    if (point_seen) begin
                        number_closed = 1'b1;
                    end else begin
                        point_seen = 1'b1;
                    end
                end else if (!point_seen) begin
                    int_part = (int_part * 10 + digit > WHOLE_MAX) ? WHOLE_MAX
                                                                    : int_part * 10 + digit;
                end else if (dec_count < FRAC_DIGITS_MAX) begin
                    dec_part = dec_part * 10 + digit;
                    dec_count++;
                end
            end
        end
        if (w.frame_end) begin
            angle = 0;
            if (frame_servo != SERVO_NONE) begin
                angle = int_part * 100 + ((dec_count == 1) ? dec_part * 10 : dec_part);
                if (angle > FULL_SCALE) begin
                    angle = FULL_SCALE;
                end
            end
            cmd.servo_select     = frame_servo;
            cmd.angle_hundredths = 15'(angle);
            parsed_commands.push_back(cmd);
            frame_servo   = SERVO_NONE;
            last_char     = '0;
            kept_chars    = 0;
            point_seen    = 1'b0;
            number_closed = 1'b0;
            int_part      = 0;
            dec_part      = 0;
            dec_count     = 0;
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic last);
        t_in_word w;
        w.rx_byte   = c;
        w.frame_end = last;
        tx_words.push_back(w);
        bytes_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            push_char(s[k], k == s.len() - 1);
        end
    endtask

    task automatic queue_random_frame();
        logic [7:0]  frame_chars[$];
        int unsigned kind;
        int unsigned r;
        int          body_start;
        string       txt;
        kind = $urandom_range(0, 99);
        body_start = 1000;
        if (kind < 25) begin
            repeat ($urandom_range(1, 10)) frame_chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3)) frame_chars.push_back(8'($urandom_range(0, 255)));
            frame_chars.push_back($urandom_range(0, 1) ? CHAR_ONE : CHAR_TWO);
            frame_chars.push_back(CHAR_UNDERSCORE);
            body_start = frame_chars.size();
            if (kind < 30) begin
                repeat ($urandom_range(30, 40)) begin
                    frame_chars.push_back(($urandom_range(0, 7) == 0) ? CHAR_DOT
                                          : 8'(CHAR_ZERO + $urandom_range(0, 9)));
                end
            end else if (kind >= 35) begin
                r = $urandom_range(0, 9);
                if (r == 1) begin
                    txt = $sformatf("%0d", $urandom_range(0, 99999));
                end else if (r == 2) begin
                    txt = $sformatf("0%0d", $urandom_range(0, 185));
                end else if (r != 0) begin
                    txt = $sformatf("%0d", $urandom_range(0, 185));
                end else begin
                    txt = "";
                end
                for (int k = 0; k < txt.len(); k++) begin
                    frame_chars.push_back(txt[k]);
                end
                if ($urandom_range(0, 3) != 0) begin
                    frame_chars.push_back(CHAR_DOT);
                    repeat ($urandom_range(0, 4)) begin
                        frame_chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                    end
                end
                if ($urandom_range(0, 6) == 0) begin
                    frame_chars.push_back(CHAR_DOT);
                    repeat ($urandom_range(0, 2)) begin
                        frame_chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                    end
                end
            end
        end
        // scatter stray characters through the number part
        for (int k = 0; k < frame_chars.size(); k++) begin
            if (k >= body_start && $urandom_range(0, 9) == 0) begin
                push_char(8'($urandom_range(0, 255)), 1'b0);
            end
            push_char(frame_chars[k], k == frame_chars.size() - 1);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parse_char(i_in_word);
                bytes_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap != 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (tx_words.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
                    in_gap = $urandom_range(0, IDLE_BURST_MAX - 1);
                    i_in_valid <= 1'b0;
                end else if (tx_words.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= tx_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (parsed_commands.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word servo %0d angle %0d",
                                            o_out_word.servo_select,
                                            o_out_word.angle_hundredths));
                end else begin
                    oldest_command = parsed_commands.pop_front();
                    frames_checked++;
                    if (o_out_word.servo_select != oldest_command.servo_select) begin
                        flag_mismatch($sformatf("servo_select %0d, want %0d",
                                                o_out_word.servo_select,
                                                oldest_command.servo_select));
                    end
                    if (o_out_word.angle_hundredths != oldest_command.angle_hundredths) begin
                        flag_mismatch($sformatf("angle_hundredths %0d, want %0d",
                                                o_out_word.angle_hundredths,
                                                oldest_command.angle_hundredths));
                    end
                end
            end
            if (out_gap != 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < out_idle_pct) begin
                out_gap = $urandom_range(0, IDLE_BURST_MAX - 1);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        in_idle_pct  = 30;
        out_idle_pct = 30;
        queue_text("1_90.5");
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b1);
        queue_text("2_");
        queue_text("1_.");
        queue_text("1");
        queue_text("_4");
        queue_text("2_1.234.5");
        queue_text("1_999");
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (tx_words.size() != 0) @(posedge i_clk);

        in_idle_pct  = 25;
        out_idle_pct = 25;
        segment_end  = bytes_queued + 400;
        while (bytes_queued < segment_end) queue_random_frame();
        while (tx_words.size() != 0) @(posedge i_clk);

        in_idle_pct  = 0;
        out_idle_pct = 45;
        segment_end  = bytes_queued + 280;
        while (bytes_queued < segment_end) queue_random_frame();
        while (tx_words.size() != 0) @(posedge i_clk);

        in_idle_pct  = 45;
        out_idle_pct = 0;
        segment_end  = bytes_queued + 250;
        while (bytes_queued < segment_end) queue_random_frame();
        while (tx_words.size() != 0) @(posedge i_clk);

        // run the tail at full rate
        in_idle_pct  = 0;
        out_idle_pct = 0;
        segment_end  = bytes_queued + 200;
        while (bytes_queued < segment_end) queue_random_frame();
        while (tx_words.size() != 0 || i_in_valid || parsed_commands.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("covered %0d bytes in %0d checked frames, with and without idling on both sides",
                 bytes_taken, frames_checked);
        if (error_count == 0) begin
            $display("[servo_angle_command_parser] OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("[servo_angle_command_parser] ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d words still pending", tx_words.size());
        $display("[servo_angle_command_parser] ERROR");
        $finish;
    end

endmodule
